// File: rtl/dad_pkg.sv
// Package for the date adder: microcode types, control store and calendar constants.
// Depends on nothing; used by the top level.
package dad_pkg;

  // Calendar and result constants
  localparam logic [13:0] YEAR_TOP   = 14'h3FFF;
  localparam logic [3:0]  MONTH_LAST = 4'd11;
  localparam logic [4:0]  DAY_LAST   = 5'd30;
  localparam logic [8:0]  YEAR_DAYS  = 9'd365;
  localparam logic [8:0]  LEAP_DAYS  = 9'd366;
  // floor(y * 5243 / 2^19) == y / 100 for every 14-bit year
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          RECIP_SH   = 19;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DAYS = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  // Microcode step addresses
  typedef enum logic [2:0] {
    PC_IDLE, PC_CHK, PC_PROD, PC_MOD, PC_MACC, PC_YEAR, PC_MON, PC_FIN
  } pc_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_TRUE, C_FALSE, C_IN_VALID, C_ADD_ZERO, C_M_AT_MONTH,
    C_Y_FITS, C_Y_TOP, C_M_FITS, C_OUT_FREE
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_ZERO, OP_INIT, OP_PROD, OP_MOD, OP_MACC,
    OP_MCLR, OP_YSUB, OP_SAT, OP_MSUB, OP_EMIT
  } op_t;

  // One control word: two prioritized conditional arms and a fall-through arm
  typedef struct packed {
    cond_t c1;
    op_t   op1;
    pc_t   t1;
    cond_t c2;
    op_t   op2;
    pc_t   t2;
    op_t   op3;
    pc_t   t3;
  } ucw_t;

  // Control store
  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    w = '{C_FALSE, OP_NOP, PC_IDLE, C_FALSE, OP_NOP, PC_IDLE, OP_NOP, PC_IDLE};
    unique case (pc)
      PC_IDLE: w = '{C_IN_VALID, OP_LOAD, PC_CHK, C_FALSE, OP_NOP, PC_IDLE,
                     OP_NOP, PC_IDLE};
      PC_CHK:  w = '{C_ADD_ZERO, OP_ZERO, PC_FIN, C_FALSE, OP_NOP, PC_IDLE,
                     OP_INIT, PC_PROD};
      PC_PROD: w = '{C_TRUE, OP_PROD, PC_MOD, C_FALSE, OP_NOP, PC_IDLE,
                     OP_NOP, PC_IDLE};
      PC_MOD:  w = '{C_TRUE, OP_MOD, PC_MACC, C_FALSE, OP_NOP, PC_IDLE,
                     OP_NOP, PC_IDLE};
      PC_MACC: w = '{C_M_AT_MONTH, OP_NOP, PC_YEAR, C_FALSE, OP_NOP, PC_IDLE,
                     OP_MACC, PC_MACC};
      PC_YEAR: w = '{C_Y_FITS, OP_MCLR, PC_MON, C_Y_TOP, OP_SAT, PC_FIN,
                     OP_YSUB, PC_YEAR};
      PC_MON:  w = '{C_M_FITS, OP_NOP, PC_FIN, C_FALSE, OP_NOP, PC_IDLE,
                     OP_MSUB, PC_MON};
      PC_FIN:  w = '{C_OUT_FREE, OP_EMIT, PC_IDLE, C_FALSE, OP_NOP, PC_IDLE,
                     OP_NOP, PC_FIN};
      default: w = '{C_FALSE, OP_NOP, PC_IDLE, C_FALSE, OP_NOP, PC_IDLE,
                     OP_NOP, PC_IDLE};
    endcase
    return w;
  endfunction

  // Month length in days, February by leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1:                     n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/dad_if.sv
// Valid/ready channel interfaces for the date adder: request and result.
// Depends on nothing.
interface dad_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;
  logic [15:0] add_days;

  modport source (output valid, start_day, start_month, start_year, add_days,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, add_days,
                  output ready);
endinterface

interface dad_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  end_day;
  logic [3:0]  end_month;
  logic [13:0] end_year;
  logic [1:0]  status;

  modport source (output valid, end_day, end_month, end_year, status,
                  input ready);
  modport sink   (input valid, end_day, end_month, end_year, status,
                  output ready);
endinterface

// File: rtl/date_add_days_top.sv
// Gregorian date adder: microcoded sequencer over a small calendar datapath.
// Depends on dad_pkg (control store, constants) and dad_if.sv (channels).
//
// Usage:
//   in_ch  : request transactions (start_day, start_month, start_year, add_days).
//   out_ch : result transactions (end_day, end_month, end_year, status).
//   A request is taken only while the sequencer sits at its idle step; one
//   request is worked at a time. The walk runs: check, reciprocal multiply,
//   mod-100 setup, summing the months before the clamped start month, stepping
//   over each whole year crossed (at most about 180 for a 16-bit day count) and
//   each whole month crossed, then loading the result. A year walk that reaches
//   the top year without fitting saturates and goes to the load with status 2.
//   A zero day count goes from the check straight to the load with status 1.
//   The sequencer returns to its idle step as the result loads, so a request
//   is not taken before the last one's result is loaded.
//   The result sits in an output register: the next request is taken while it
//   waits, and the sequencer holds at its last step only if a second result is
//   ready before the first is taken.
//   Reset (synchronous, active low) returns the sequencer to idle and drops out_ch.valid.
module date_add_days_top
  import dad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  dad_in_if.sink   in_ch,
  dad_out_if.source out_ch
);

  typedef struct packed {
    logic in_valid;
    logic add_zero;
    logic m_at_month;
    logic y_fits;
    logic y_top;
    logic m_fits;
    logic out_free;
  } flags_t;

  function automatic logic cond_hit(input cond_t c, input flags_t f);
    logic h;
    unique case (c)
      C_TRUE:       h = 1'b1;
      C_FALSE:      h = 1'b0;
      C_IN_VALID:   h = f.in_valid;
      C_ADD_ZERO:   h = f.add_zero;
      C_M_AT_MONTH: h = f.m_at_month;
      C_Y_FITS:     h = f.y_fits;
      C_Y_TOP:      h = f.y_top;
      C_M_FITS:     h = f.m_fits;
      C_OUT_FREE:   h = f.out_free;
      default:      h = 1'b0;
    endcase
    return h;
  endfunction

  // Sequencer and datapath registers
  pc_t         pc_r, pc_nxt;
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic [15:0] add_r;
  logic [16:0] off_r;
  logic [3:0]  m_r;
  logic [1:0]  status_r;
  logic [26:0] prod_r;
  logic [6:0]  r100_r;
  logic [1:0]  c4_r;
  logic        out_valid_r;
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [13:0] out_year_r;
  logic [1:0]  out_status_r;

  ucw_t        cw;
  op_t         op;
  flags_t      flags;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  month_cl;
  logic [7:0]  q100;
  logic [13:0] q100_x100;

  // Leap flag from year mod 4, mod 100 and (year / 100) mod 4
  assign leap     = (year_r[1:0] == 2'd0) && ((r100_r != 7'd0) || (c4_r == 2'd0));
  assign ylen     = leap ? LEAP_DAYS : YEAR_DAYS;
  assign mlen     = month_len(m_r, leap);
  assign month_cl = (month_r > MONTH_LAST) ? MONTH_LAST : month_r;
  assign q100      = prod_r[RECIP_SH +: 8];
  assign q100_x100 = 14'({6'd0, q100} * 14'd100);

  // Condition flags
  always_comb begin
    flags.in_valid   = in_ch.valid;
    flags.add_zero   = (add_r == 16'd0);
    flags.m_at_month = (m_r == month_cl);
    flags.y_fits     = (off_r < {8'd0, ylen});
    flags.y_top      = (year_r == YEAR_TOP);
    flags.m_fits     = (off_r < {12'd0, mlen}) || (m_r == MONTH_LAST);
    flags.out_free   = !out_valid_r || out_ch.ready;
  end

  // Control word decode and next step
  always_comb begin
    cw = ucode(pc_r);
    if (cond_hit(cw.c1, flags)) begin
      op     = cw.op1;
      pc_nxt = cw.t1;
    end else if (cond_hit(cw.c2, flags)) begin
      op     = cw.op2;
      pc_nxt = cw.t2;
    end else begin
      op     = cw.op3;
      pc_nxt = cw.t3;
    end
  end

  // Step counter, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      // a new result replaces one taken at the same edge
      if (op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_NOP: ;
        OP_LOAD: begin
          day_r   <= in_ch.start_day;
          month_r <= in_ch.start_month;
          year_r  <= in_ch.start_year;
          add_r   <= in_ch.add_days;
        end
        OP_ZERO: begin
          off_r    <= {12'd0, day_r};
          m_r      <= month_r;
          status_r <= ST_NO_DAYS;
        end
        OP_INIT: begin
          off_r    <= {12'd0, day_r} + {1'b0, add_r};
          m_r      <= 4'd0;
          status_r <= ST_OK;
        end
        OP_PROD: prod_r <= 27'(year_r) * 27'(RECIP_100);
        OP_MOD: begin
          r100_r <= 7'(year_r - q100_x100);
          c4_r   <= q100[1:0];
        end
        OP_MACC: begin
          off_r <= off_r + {12'd0, mlen};
          m_r   <= m_r + 4'd1;
        end
        OP_MCLR: m_r <= 4'd0;
        OP_YSUB: begin
          off_r  <= off_r - {8'd0, ylen};
          year_r <= year_r + 14'd1;
          if (r100_r == 7'd99) begin
            r100_r <= 7'd0;
            c4_r   <= c4_r + 2'd1;
          end else begin
            r100_r <= r100_r + 7'd1;
          end
        end
        OP_SAT: begin
          off_r    <= {12'd0, DAY_LAST};
          m_r      <= MONTH_LAST;
          year_r   <= YEAR_TOP;
          status_r <= ST_OVF;
        end
        OP_MSUB: begin
          off_r <= off_r - {12'd0, mlen};
          m_r   <= m_r + 4'd1;
        end
        OP_EMIT: begin
          out_day_r    <= off_r[4:0];
          out_month_r  <= m_r;
          out_year_r   <= year_r;
          out_status_r <= status_r;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready      = (pc_r == PC_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.end_day   = out_day_r;
  assign out_ch.end_month = out_month_r;
  assign out_ch.end_year  = out_year_r;
  assign out_ch.status    = out_status_r;

endmodule

// File: rtl/dad_checker.sv
// Port-level checks for the date adder, bound to date_add_days_top.
// Depends on dad_pkg for status codes and calendar limits.
module dad_checker
  import dad_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  end_day,
  input logic [3:0]  end_month,
  input logic [13:0] end_year,
  input logic [1:0]  status
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_NO_DAYS || status == ST_OVF))
    else $error("undefined status code");

  // A normal result has its month and day within the calendar bounds
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> end_month <= MONTH_LAST && end_day <= DAY_LAST)
    else $error("ok result out of calendar range");

  // Overflow saturates to the last day of the top year
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OVF |->
      end_year == YEAR_TOP && end_month == MONTH_LAST && end_day == DAY_LAST)
    else $error("overflow result not saturated");

endmodule

bind date_add_days_top dad_checker u_dad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .end_day   (out_ch.end_day),
  .end_month (out_ch.end_month),
  .end_year  (out_ch.end_year),
  .status    (out_ch.status)
);
